@@ rtl/core/adc_voltmeter_seven_segment_assert.svh @@
// Assertion macros used by the voltmeter display driver back end.
`ifndef ADC_VOLTMETER_SEVEN_SEGMENT_ASSERT_SVH
`define ADC_VOLTMETER_SEVEN_SEGMENT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define AVSS_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define AVSS_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/core/avss_pkg.sv @@
// Package: widths, constants, item types and segment font for the voltmeter driver.
package avss_pkg;

    // Field widths
    localparam int SAMPLE_W = 14;
    localparam int DUTY_W   = 8;
    localparam int SEG_W    = 8;
    localparam int POS_W    = 2;
    localparam int CENTI_W  = 9;   // hundredths of a volt, 0..331
    localparam int DIGIT_W  = 4;
    localparam int REM_W    = 7;   // remainder below one hundred

    // Scaling: centi = floor((sample * 330 + 8167) / 16334)
    localparam int NUM_W       = 23;
    localparam int RECIP_W     = 24;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 37;
    localparam logic [NUM_W-1:0]   VOLT_NUM   = NUM_W'(330);
    localparam logic [NUM_W-1:0]   ROUND_BIAS = NUM_W'(16334 / 2);
    // ceil(2^37 / 16334); exact for every numerator below 2^23
    localparam logic [RECIP_W-1:0] VOLT_RECIP = RECIP_W'(8414287);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Digit slot codes
    localparam logic [POS_W-1:0] SLOT_BLANK = 2'd0;
    localparam logic [POS_W-1:0] SLOT_HUND  = 2'd1;
    localparam logic [POS_W-1:0] SLOT_TENS  = 2'd2;
    localparam logic [POS_W-1:0] SLOT_ONES  = 2'd3;

    // Segment constants
    localparam logic [SEG_W-1:0] SEG_ALL = 8'hFF;
    localparam logic [SEG_W-1:0] SEG_DP  = 8'h80;

    // Item between front and back
    typedef struct packed {
        logic [CENTI_W-1:0] centi;
        logic [DUTY_W-1:0]  duty_u;
    } reading_t;

    // Active-high segment pattern a..g for a decimal digit; blank otherwise
    function automatic logic [SEG_W-1:0] font_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] pat;
        case (d)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h67;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

@@ rtl/core/avss_if.sv @@
// Valid/ready channel interfaces for samples in and digit slots out.
interface avss_sample_if
    import avss_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface avss_slot_if
    import avss_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  digit_position;
    logic [SEG_W-1:0]  segments_n;
    logic [DUTY_W-1:0] duty_u;
    logic [DUTY_W-1:0] duty_v;
    logic              last;

    modport source (output valid, output digit_position, output segments_n,
                    output duty_u, output duty_v, output last, input ready);
    modport sink   (input valid, input digit_position, input segments_n,
                    input duty_u, input duty_v, input last, output ready);
endinterface

@@ rtl/core/avss_front.sv @@
// Front end: accepts samples, scales to hundredths of a volt, pushes readings.
module avss_front
    import avss_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    avss_sample_if.sink   sample,
    output logic          push,
    output reading_t      push_item,
    input  logic          full
);

    logic              valid_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic [NUM_W-1:0]  num_next;
    logic [PROD_W-1:0] prod;
    logic              take;

    // Stage holds one item; it frees when the queue takes it
    assign sample.ready = !valid_reg || !full;
    assign take         = sample.valid && sample.ready;
    assign push         = valid_reg && !full;

    // Numerator with rounding bias: sample * 330 + 8167
    assign num_next = NUM_W'(sample.adc_sample) * VOLT_NUM + ROUND_BIAS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            num_reg  <= num_next;
            duty_reg <= sample.adc_sample[SAMPLE_W-1 -: DUTY_W];
        end
    end

    // Divide by 16334 through the reciprocal
    assign prod             = PROD_W'(num_reg) * PROD_W'(VOLT_RECIP);
    assign push_item.centi  = prod[RECIP_SHIFT +: CENTI_W];
    assign push_item.duty_u = duty_reg;

endmodule

@@ rtl/core/avss_queue.sv @@
// Short FIFO of scaled readings between front and back.
module avss_queue
    import avss_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  reading_t push_item,
    output logic     full,
    output logic     head_valid,
    output reading_t head_item,
    input  logic     pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    reading_t         store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = store[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/avss_back.sv @@
// Back end: splits a reading into digits and emits four display slots.
module avss_back
    import avss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         head_valid,
    input  reading_t     head_item,
    output logic         pop,
    avss_slot_if.source  display
);

`include "adc_voltmeter_seven_segment_assert.svh"

    logic [POS_W-1:0]   slot_reg;
    logic               out_valid_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic               last_reg;

    logic               load;
    logic [DIGIT_W-1:0] hund;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
    logic [CENTI_W-1:0] hund_part;
    logic [REM_W-1:0]   rem;
    logic [REM_W-1:0]   tens_part;
    logic [SEG_W-1:0]   seg_next;
    logic               pos_blank;
    logic               pos_ones;
    logic               slot_taken;

    // Hundreds by comparison (value never reaches 400)
    always_comb
    begin
        if (head_item.centi >= CENTI_W'(300))
        begin
            hund      = DIGIT_W'(3);
            hund_part = CENTI_W'(300);
        end
        else if (head_item.centi >= CENTI_W'(200))
        begin
            hund      = DIGIT_W'(2);
            hund_part = CENTI_W'(200);
        end
        else if (head_item.centi >= CENTI_W'(100))
        begin
            hund      = DIGIT_W'(1);
            hund_part = CENTI_W'(100);
        end
        else
        begin
            hund      = '0;
            hund_part = '0;
        end
    end

    assign rem = REM_W'(head_item.centi - hund_part);

    // Tens: count of thresholds reached, compares run in parallel
    always_comb
    begin
        tens = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem >= REM_W'(10 * k))
            begin
                tens = DIGIT_W'(k);
            end
        end
    end

    assign tens_part = REM_W'(tens) * REM_W'(10);
    assign ones      = DIGIT_W'(rem - tens_part);

    // Segment pattern for the slot about to go out
    always_comb
    begin
        case (slot_reg)
            SLOT_BLANK: seg_next = SEG_ALL;
            SLOT_HUND:  seg_next = ~(font_of(hund) | SEG_DP);
            SLOT_TENS:  seg_next = ~font_of(tens);
            SLOT_ONES:  seg_next = ~font_of(ones);
            default:    seg_next = SEG_ALL;
        endcase
    end

    // Output register takes a new slot when an item is waiting and it is empty or drained
    assign load = head_valid && (!out_valid_reg || display.ready);
    assign pop  = load && (slot_reg == SLOT_ONES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            slot_reg      <= SLOT_BLANK;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                slot_reg      <= slot_reg + POS_W'(1);
            end
            else if (display.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg  <= slot_reg;
            seg_reg  <= seg_next;
            duty_reg <= head_item.duty_u;
            last_reg <= (slot_reg == SLOT_ONES);
        end
    end

    assign display.valid          = out_valid_reg;
    assign display.digit_position = pos_reg;
    assign display.segments_n     = seg_reg;
    assign display.duty_u         = duty_reg;
    assign display.duty_v         = ~duty_reg;
    assign display.last           = last_reg;

    // Checks
    assign pos_blank  = (pos_reg == SLOT_BLANK);
    assign pos_ones   = (pos_reg == SLOT_ONES);
    assign slot_taken = out_valid_reg && display.ready;

    `AVSS_ASSERT_IMP(a_last_on_ones, out_valid_reg, last_reg == pos_ones, "stray last")
    `AVSS_ASSERT_IMP(a_blank_slot, out_valid_reg && pos_blank, seg_reg == SEG_ALL, "lit blank")
    `AVSS_ASSERT_NXT(a_no_gap, slot_taken && !last_reg, out_valid_reg && !pos_blank, "gap in run")
    `AVSS_ASSERT_IMP(a_pop_needs_item, pop, head_valid, "pop from empty queue")

endmodule

@@ rtl/core/adc_voltmeter_seven_segment.sv @@
// Top level: ADC voltmeter seven-segment digit driver with PWM duties.
// Each accepted 14-bit sample is scaled to hundredths of a volt
// (round(sample * 330 / 16334), 0..331) and leaves as four display slots in
// order: a blank digit, hundreds with the decimal point, tens, ones; segments
// are active low and every slot carries duty_u = sample / 64 and
// duty_v = 255 - duty_u. The back end sends one slot per cycle through its
// single output register while the display side keeps ready high and the
// queue holds an item. An accepted sample passes the scaling register, the
// queue entry and the output register, in that order, before its first
// slot is valid. A two-entry queue between scaling and digit output lets
// the sample side keep accepting while the display side stalls.
module adc_voltmeter_seven_segment
    import avss_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    avss_sample_if.sink  sample,
    avss_slot_if.source  display
);

    logic     push;
    reading_t push_item;
    logic     full;
    logic     head_valid;
    reading_t head_item;
    logic     pop;

    avss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    avss_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    avss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .display    (display)
    );

endmodule
